// ----- src/utf8_char_decode_validate_defines.svh -----
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_CHAR_DECODE_VALIDATE_DEFINES_SVH
`define UTF8_CHAR_DECODE_VALIDATE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define U8D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("utf8 decoder assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define U8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8 decoder assertion failed");

`else

`define U8D_ASSERT(lbl, prop)
`define U8D_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/u8dec_pkg.sv -----
// Types and constants shared by the UTF-8 decoder pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
package u8dec_pkg;

  // Well-formed ranges and the bit patterns of each sequence length.
  localparam logic [31:0] AsciiHi     = 32'h0000_007F;
  localparam logic [31:0] TwoLo       = 32'h0000_C280;
  localparam logic [31:0] TwoHi       = 32'h0000_DFBF;
  localparam logic [31:0] TwoMask     = 32'h0000_E0C0;
  localparam logic [31:0] TwoPattern  = 32'h0000_C080;
  localparam logic [31:0] SurrLo      = 32'h00ED_A080;
  localparam logic [31:0] SurrHi      = 32'h00ED_BFBF;
  localparam logic [31:0] ThreeLo     = 32'h00E0_A080;
  localparam logic [31:0] ThreeHi     = 32'h00EF_BFBF;
  localparam logic [31:0] ThreeMask   = 32'h00F0_C0C0;
  localparam logic [31:0] ThreePat    = 32'h00E0_8080;
  localparam logic [31:0] FourLo      = 32'hF090_8080;
  localparam logic [31:0] FourHi      = 32'hF48F_BFBF;
  localparam logic [31:0] FourMask    = 32'hF8C0_C0C0;
  localparam logic [31:0] FourPattern = 32'hF080_8080;

  // Masks used to pull the scalar value out of a packed sequence.
  localparam logic [31:0] LeadBits    = 32'h0700_0000;
  localparam logic [31:0] MidNarrow   = 32'h000F_0000;
  localparam logic [31:0] MidWide     = 32'h003F_0000;
  localparam logic [31:0] ThirdBits   = 32'h0000_3F00;
  localparam logic [31:0] LastBits    = 32'h0000_003F;

  // Item leaving the packing stage.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  len;
    logic [7:0]  lead;
  } pack_t;

  // Item leaving the checking stage.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  len;
    logic [7:0]  lead;
    logic [20:0] scalar;
    logic        bad;
  } chk_t;

endpackage
`default_nettype wire

// ----- src/u8dec_pack.sv -----
// First pipeline stage: sequence length lookup and big-endian byte packing.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [7:0]      byte0_i,
  input  logic [7:0]      byte1_i,
  input  logic [7:0]      byte2_i,
  input  logic [7:0]      byte3_i,
  output logic            valid_o,
  input  logic            stall_i,
  output u8dec_pkg::pack_t data_o
);
  import u8dec_pkg::*;

  // Length from the lead byte's upper nibble; continuation bytes give zero.
  function automatic logic [2:0] seq_len(input logic [3:0] nib);
    logic [2:0] len;
    unique case (nib)
      4'h8, 4'h9, 4'hA, 4'hB: len = 3'd0;
      4'hC, 4'hD:             len = 3'd2;
      4'hE:                   len = 3'd3;
      4'hF:                   len = 3'd4;
      default:                len = 3'd1;
    endcase
    return len;
  endfunction

  logic       valid_q;
  pack_t      data_q;
  pack_t      data_d;
  logic [2:0] len;
  logic       take0, take1, take2, take3;

  always_comb begin
    len   = seq_len(byte0_i[7:4]);
    // Packing stops at the first zero byte or at the sequence length.
    take0 = (len >= 3'd1) && (byte0_i != 8'h00);
    take1 = take0 && (len >= 3'd2) && (byte1_i != 8'h00);
    take2 = take1 && (len >= 3'd3) && (byte2_i != 8'h00);
    take3 = take2 && (len >= 3'd4) && (byte3_i != 8'h00);
    if (take3) begin
      data_d.word = {byte0_i, byte1_i, byte2_i, byte3_i};
    end else if (take2) begin
      data_d.word = {8'h00, byte0_i, byte1_i, byte2_i};
    end else if (take1) begin
      data_d.word = {16'h0000, byte0_i, byte1_i};
    end else if (take0) begin
      data_d.word = {24'h00_0000, byte0_i};
    end else begin
      data_d.word = 32'h0000_0000;
    end
    data_d.len  = len;
    data_d.lead = byte0_i;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ----- src/u8dec_check.sv -----
// Second pipeline stage: range validation and scalar value extraction.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_check (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  u8dec_pkg::pack_t data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output u8dec_pkg::chk_t  data_o
);
  import u8dec_pkg::*;

  logic        valid_q;
  chk_t        data_q;
  chk_t        data_d;
  logic        well_formed;
  logic [31:0] mid_mask;
  logic [31:0] scalar_full;

  always_comb begin
    // Ranges are tried in order; surrogates fall out before the three-byte test.
    if (data_i.word <= AsciiHi) begin
      well_formed = 1'b1;
    end else if (data_i.word >= TwoLo && data_i.word <= TwoHi) begin
      well_formed = (data_i.word & TwoMask) == TwoPattern;
    end else if (data_i.word >= SurrLo && data_i.word <= SurrHi) begin
      well_formed = 1'b0;
    end else if (data_i.word >= ThreeLo && data_i.word <= ThreeHi) begin
      well_formed = (data_i.word & ThreeMask) == ThreePat;
    end else if (data_i.word >= FourLo && data_i.word <= FourHi) begin
      well_formed = (data_i.word & FourMask) == FourPattern;
    end else begin
      well_formed = 1'b0;
    end

    mid_mask = (data_i.word <= ThreeHi) ? MidNarrow : MidWide;
    if (data_i.word <= AsciiHi) begin
      scalar_full = data_i.word;
    end else begin
      scalar_full = ((data_i.word & LeadBits) >> 6) | ((data_i.word & mid_mask) >> 4) |
                    ((data_i.word & ThirdBits) >> 2) | (data_i.word & LastBits);
    end

    data_d.word   = data_i.word;
    data_d.len    = data_i.len;
    data_d.lead   = data_i.lead;
    data_d.scalar = scalar_full[20:0];
    data_d.bad    = (data_i.len == 3'd0) || !well_formed;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ----- src/u8dec_select.sv -----
// Third pipeline stage: result selection into the output register.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_select (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  u8dec_pkg::chk_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [2:0]      consumed_o,
  output logic [31:0]     packed_encoding_o,
  output logic [20:0]     codepoint_o,
  output logic            invalid_o
);
  import u8dec_pkg::*;

  logic        valid_q;
  logic [2:0]  consumed_q,  consumed_d;
  logic [31:0] packed_q,    packed_d;
  logic [20:0] codepoint_q, codepoint_d;
  logic        invalid_q,   invalid_d;

  always_comb begin
    // A rejected sequence falls back to the single raw lead byte.
    if (data_i.bad) begin
      packed_d    = {24'h00_0000, data_i.lead};
      consumed_d  = (data_i.lead != 8'h00) ? 3'd1 : 3'd0;
      codepoint_d = 21'd0;
      invalid_d   = 1'b1;
    end else begin
      packed_d    = data_i.word;
      consumed_d  = (data_i.word != 32'h0000_0000) ? data_i.len : 3'd0;
      codepoint_d = data_i.scalar;
      invalid_d   = 1'b0;
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      consumed_q  <= consumed_d;
      packed_q    <= packed_d;
      codepoint_q <= codepoint_d;
      invalid_q   <= invalid_d;
    end
  end

  assign valid_o           = valid_q;
  assign consumed_o        = consumed_q;
  assign packed_encoding_o = packed_q;
  assign codepoint_o       = codepoint_q;
  assign invalid_o         = invalid_q;

endmodule
`default_nettype wire

// ----- src/utf8_char_decode_validate.sv -----
// Top level of the UTF-8 character decoder and validator pipeline.
// An accepted item passes through the pack, check and select registers in turn.
// Throughput: one item per cycle while the output is not stalled; each of the three stages holds one item.
// A stage refills in the same cycle its item moves on, so bubbles close up.
// Reset clears only the stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_char_decode_validate_defines.svh"
module utf8_char_decode_validate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  first_byte_i,
  input  logic [7:0]  second_byte_i,
  input  logic [7:0]  third_byte_i,
  input  logic [7:0]  fourth_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  consumed_o,
  output logic [31:0] packed_encoding_o,
  output logic [20:0] codepoint_o,
  output logic        invalid_o
);
  import u8dec_pkg::*;

  // Each stage stalls its upstream neighbour only while it holds an item
  // that its own downstream neighbour cannot take, so an empty stage always
  // accepts even when the output register is waiting.
  logic  pack_valid;
  logic  pack_stall;
  pack_t pack_data;
  logic  chk_valid;
  logic  chk_stall;
  chk_t  chk_data;
  logic  sel_stall;

  // Stage one: the lead byte's nibble sets the length and the window bytes
  // are packed big-endian up to that length or the first zero byte.
  u8dec_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .byte0_i (first_byte_i),
    .byte1_i (second_byte_i),
    .byte2_i (third_byte_i),
    .byte3_i (fourth_byte_i),
    .valid_o (pack_valid),
    .stall_i (pack_stall),
    .data_o  (pack_data)
  );

  // Stage two: the packed word is compared against the well-formed ranges,
  // and the scalar value is extracted in parallel.
  u8dec_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pack_valid),
    .stall_o (pack_stall),
    .data_i  (pack_data),
    .valid_o (chk_valid),
    .stall_i (chk_stall),
    .data_o  (chk_data)
  );

  // Stage three: the result fields are chosen and held in the output register.
  u8dec_select u_select (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (chk_valid),
    .stall_o           (sel_stall),
    .data_i            (chk_data),
    .valid_o           (out_valid_o),
    .stall_i           (out_stall_i),
    .consumed_o        (consumed_o),
    .packed_encoding_o (packed_encoding_o),
    .codepoint_o       (codepoint_o),
    .invalid_o         (invalid_o)
  );

  assign chk_stall = sel_stall;

  // An invalid result always consumes exactly the lead byte and has no scalar.
  `U8D_ASSERT(a_invalid_shape,
    !(out_valid_o && invalid_o) || (consumed_o == 3'd1 && codepoint_o == 21'd0))

  // End of text gives an all-zero result.
  `U8D_ASSERT(a_end_of_text,
    !(out_valid_o && !invalid_o && consumed_o == 3'd0) ||
    (packed_encoding_o == 32'h0000_0000 && codepoint_o == 21'd0))

  // A valid scalar is never a surrogate and never above the Unicode range.
  `U8D_ASSERT(a_scalar_range,
    !(out_valid_o && !invalid_o) ||
    (codepoint_o <= 21'h10_FFFF && (codepoint_o < 21'h00_D800 || codepoint_o > 21'h00_DFFF)))

  // An accepted item always lands in the first stage.
  `U8D_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, pack_valid)

endmodule
`default_nettype wire
